>>> rtl/core/ifbs_pkg.sv
// Shared constants and the command type passed from front to back of the byte stuffer.
package ifbs_pkg;

	localparam logic [7:0] FLAG_BYTE     = 8'h7E;
	localparam logic [7:0] ESC_BYTE      = 8'h7D;
	localparam logic [7:0] ESC_MASK      = 8'h20;
	localparam int unsigned SEQ_SHIFT    = 6;
	localparam logic [7:0] ADDR_RESET    = 8'h03;

	localparam int unsigned QUEUE_DEPTH  = 4;
	localparam int unsigned QPTR_W       = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W       = $clog2(QUEUE_DEPTH + 1);

	localparam int unsigned PADDR_W      = 3;
	localparam logic        REG_SENDER_ADDRESS = 1'b0;

	// One classified input item, ready for the back end to serialize.
	typedef struct packed {
		logic       hdr;      // emit frame header first
		logic       esc;      // payload byte needs an escape
		logic       last;     // close the frame after the payload
		logic       seq;      // sequence bit for the control byte
		logic [7:0] addr;     // address sampled with each item
		logic [7:0] data;     // raw payload byte
		logic [7:0] check;    // running check after this byte
	} cmd_t;

	function automatic logic [7:0] ctrl_byte(input logic seq);
		logic [7:0] c;
		c = 8'h00;
		c[SEQ_SHIFT] = seq;
		return c;
	endfunction

endpackage

>>> rtl/core/info_frame_byte_stuffer.sv
// Top level of the information frame byte stuffer: config register, front, queue, back.
//
//  channel  | dir | handshake         | payload
//  ---------+-----+-------------------+------------------------------------------------
//  s_axis   | in  | s_tvalid/s_tready | tdata[7:0] data_byte, tlast last_byte,
//           |     |                   | tuser[0] first_byte, tuser[1] sequence_bit
//  m_axis   | out | m_tvalid/m_tready | tdata[7:0] frame_byte, tlast run_last,
//           |     |                   | tuser[0] frame_end
//  apb      | in  | psel/penable      | paddr 0x0: sender_address (bits 7:0)
//
// Each input item yields 1 to 8 output items; the back end serializes them at one
// output item per cycle while the output is not stalled.
// Input items are taken every cycle while the 4-entry command queue has room.
// Reset clears frame state, the running check and the queue; sender_address is 3.
// Output stalls hold the output register and back up into the queue, then drop s_tready once it is full.
module info_frame_byte_stuffer (
	input  logic                          clk,
	input  logic                          arst_n,
	// input stream
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,   // [7:0] data_byte
	input  logic                          s_tlast,   // last_byte
	input  logic [1:0]                    s_tuser,   // [0] first_byte, [1] sequence_bit
	// output stream
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [7:0]                    m_tdata,   // [7:0] frame_byte
	output logic                          m_tlast,   // run_last
	output logic                          m_tuser,   // [0] frame_end
	// configuration
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ifbs_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);

	logic [7:0]      sender_address_q;
	logic            s_accept;
	logic            q_full;
	logic            q_pop;
	logic            q_valid;
	ifbs_pkg::cmd_t  front_cmd;
	ifbs_pkg::cmd_t  head_cmd;

	// APB: always ready; one register at word 0.
	assign pready = 1'b1;
	assign prdata = (paddr[2] == ifbs_pkg::REG_SENDER_ADDRESS)
		? {24'h000000, sender_address_q} : 32'h00000000;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sender_address_q <= ifbs_pkg::ADDR_RESET;
		end else if (psel && penable && pwrite && pready &&
			(paddr[2] == ifbs_pkg::REG_SENDER_ADDRESS)) begin
			sender_address_q <= pwdata[7:0];
		end
	end

	// Accept whenever the queue has a free slot.
	assign s_tready = !q_full;
	assign s_accept = s_tvalid && s_tready;

	ifbs_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (s_accept),
		.data_byte      (s_tdata),
		.first_byte     (s_tuser[0]),
		.last_byte      (s_tlast),
		.sequence_bit   (s_tuser[1]),
		.sender_address (sender_address_q),
		.cmd            (front_cmd)
	);

	ifbs_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (s_accept),
		.push_cmd   (front_cmd),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head_cmd   (head_cmd)
	);

	ifbs_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (q_valid),
		.head_cmd   (head_cmd),
		.pop        (q_pop),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.frame_byte (m_tdata),
		.run_last   (m_tlast),
		.frame_end  (m_tuser)
	);

endmodule

>>> rtl/core/ifbs_front.sv
// Front end: accept input items, track frame state and the running check, build commands.
module ifbs_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic [7:0]         data_byte,
	input  logic               first_byte,
	input  logic               last_byte,
	input  logic               sequence_bit,
	input  logic [7:0]         sender_address,
	output ifbs_pkg::cmd_t     cmd
);

	logic       inside_q;
	logic [7:0] check_q;
	logic       open_frame;
	logic [7:0] check_next;

	assign open_frame = first_byte || !inside_q;
	assign check_next = open_frame ? data_byte : (check_q ^ data_byte);

	always_comb begin
		cmd.hdr   = open_frame;
		cmd.esc   = (data_byte == ifbs_pkg::FLAG_BYTE) || (data_byte == ifbs_pkg::ESC_BYTE);
		cmd.last  = last_byte;
		cmd.seq   = sequence_bit;
		cmd.addr  = sender_address;
		cmd.data  = data_byte;
		cmd.check = check_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_q <= 1'b0;
			check_q  <= 8'h00;
		end else if (accept) begin
			check_q  <= check_next;
			inside_q <= !last_byte;
		end
	end

endmodule

>>> rtl/core/ifbs_queue.sv
// Short command queue that decouples the front end from the byte serializer.
module ifbs_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  ifbs_pkg::cmd_t     push_cmd,
	output logic               full,
	input  logic               pop,
	output logic               head_valid,
	output ifbs_pkg::cmd_t     head_cmd
);

	ifbs_pkg::cmd_t                 slot_q [ifbs_pkg::QUEUE_DEPTH];
	logic [ifbs_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [ifbs_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [ifbs_pkg::QCNT_W-1:0]    count_q;

	assign full       = (count_q == ifbs_pkg::QCNT_W'(ifbs_pkg::QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_cmd   = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> rtl/core/ifbs_back.sv
// Back end: walk the byte slots of the head command, one output byte per cycle while the output is not stalled.
module ifbs_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               head_valid,
	input  ifbs_pkg::cmd_t     head_cmd,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0]         frame_byte,
	output logic               run_last,
	output logic               frame_end
);

	typedef enum logic [2:0] {
		STEP_OPEN,
		STEP_ADDR,
		STEP_CTRL,
		STEP_HCHK,
		STEP_DATA,
		STEP_ESCD,
		STEP_CHK,
		STEP_CLOSE
	} step_t;

	step_t      step_q;
	logic       busy_q;
	step_t      step_cur;
	step_t      step_nxt;
	logic       is_final;
	logic       advance;
	logic       emit;
	logic [7:0] byte_cur;
	logic [7:0] ctrl;

	logic       out_valid_q;
	logic [7:0] byte_q;
	logic       run_last_q;
	logic       frame_end_q;

	assign ctrl     = ifbs_pkg::ctrl_byte(head_cmd.seq);
	assign step_cur = busy_q ? step_q : (head_cmd.hdr ? STEP_OPEN : STEP_DATA);
	assign advance  = !out_valid_q || out_ready;
	assign emit     = advance && head_valid;
	assign pop      = emit && is_final;

	// Next enabled slot after the current one, and whether the current one ends the item.
	always_comb begin
		step_nxt = STEP_OPEN;
		is_final = 1'b0;
		unique case (step_cur)
			STEP_OPEN:  step_nxt = STEP_ADDR;
			STEP_ADDR:  step_nxt = STEP_CTRL;
			STEP_CTRL:  step_nxt = STEP_HCHK;
			STEP_HCHK:  step_nxt = STEP_DATA;
			STEP_DATA: begin
				if (head_cmd.esc) begin
					step_nxt = STEP_ESCD;
				end else if (head_cmd.last) begin
					step_nxt = STEP_CHK;
				end else begin
					is_final = 1'b1;
				end
			end
			STEP_ESCD: begin
				if (head_cmd.last) begin
					step_nxt = STEP_CHK;
				end else begin
					is_final = 1'b1;
				end
			end
			STEP_CHK:   step_nxt = STEP_CLOSE;
			STEP_CLOSE: is_final = 1'b1;
			default:    is_final = 1'b1;
		endcase
	end

	always_comb begin
		unique case (step_cur)
			STEP_OPEN:  byte_cur = ifbs_pkg::FLAG_BYTE;
			STEP_ADDR:  byte_cur = head_cmd.addr;
			STEP_CTRL:  byte_cur = ctrl;
			STEP_HCHK:  byte_cur = head_cmd.addr ^ ctrl;
			STEP_DATA:  byte_cur = head_cmd.esc ? ifbs_pkg::ESC_BYTE : head_cmd.data;
			STEP_ESCD:  byte_cur = head_cmd.data ^ ifbs_pkg::ESC_MASK;
			STEP_CHK:   byte_cur = head_cmd.check;
			STEP_CLOSE: byte_cur = ifbs_pkg::FLAG_BYTE;
			default:    byte_cur = ifbs_pkg::FLAG_BYTE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			step_q      <= STEP_OPEN;
			out_valid_q <= 1'b0;
			byte_q      <= 8'h00;
			run_last_q  <= 1'b0;
			frame_end_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= head_valid;
			if (emit) begin
				busy_q      <= !is_final;
				step_q      <= step_nxt;
				byte_q      <= byte_cur;
				run_last_q  <= is_final;
				frame_end_q <= (step_cur == STEP_CLOSE);
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign frame_byte = byte_q;
	assign run_last   = run_last_q;
	assign frame_end  = frame_end_q;

endmodule
